/* src/dsdc_pkg.sv */
// shared types, constants and modular arithmetic for the digit sum counter
package dsdc_pkg;

  localparam int unsigned CNT_W           = 30;
  localparam int unsigned DIGIT_W         = 4;
  localparam int unsigned DIV_CFG_W       = 8;
  localparam int unsigned IN_TDATA_W      = 8;
  localparam int unsigned OUT_TDATA_W     = 32;
  localparam int unsigned DEF_MAX_DIVISOR = 128;
  localparam int unsigned DIVISOR_LIMIT   = 1024;
  localparam int unsigned ADDR_MAX_W      = $clog2(DIVISOR_LIMIT);
  // ten digit choices per position
  localparam int unsigned WIN_LEN         = 10;

  typedef logic [CNT_W-1:0] cnt_t;

  localparam cnt_t                MODULUS   = 30'd1000000007;
  localparam logic [DIGIT_W-1:0] TOP_DIGIT = 4'd9;

  // one write into a count store
  typedef struct packed {
    logic                  we;
    logic [ADDR_MAX_W-1:0] addr;
    cnt_t                  data;
  } wr_t;

  // both operands below the modulus
  function automatic cnt_t mod_add(input cnt_t a, input cnt_t b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MODULUS}) begin
      s = s - {1'b0, MODULUS};
    end
    return s[CNT_W-1:0];
  endfunction

  function automatic cnt_t mod_sub(input cnt_t a, input cnt_t b);
    logic [CNT_W:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (d[CNT_W]) begin
      d = d + {1'b0, MODULUS};
    end
    return d[CNT_W-1:0];
  endfunction

endpackage

/* src/digit_sum_divisible_counter.sv */
// top level: digit-dp counter of numbers up to a bound with divisible digit sum
//
// in_*  : one decimal digit of the bound per item, most significant first;
//         in_tlast marks the least significant digit of the bound
// out_* : one item per bound, the count of 1..K whose digit sum is divisible
//         by the divisor, modulo 1000000007
// cfg_* : write of the divisor (0 acts as 1, above MAX_DIVISOR saturates);
//         always ready, write it only between bounds
// for each digit, with dv the live divisor, one pass over the count store
// folds it to dv sums through its single read port, then a ten-wide sliding
// window over the folded store (two read ports) writes the dv new counts back,
// or zeros on a bound's last digit, which then passes an output state; its
// result is valid when the input reopens
// a reduction of a prefix left over from a larger divisor can hold back the window
// after reset the count store is cleared, one entry a cycle, and no item is
// taken until the clearing pass ends; the divisor resets to 1
// the result sits in an output register: the next bound's digits are taken
// while it waits, and only the next result waits on a stalled receiver
module digit_sum_divisible_counter #(
  parameter int unsigned MAX_DIVISOR = dsdc_pkg::DEF_MAX_DIVISOR
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [dsdc_pkg::IN_TDATA_W-1:0]      in_tdata,   // [3:0] digit
  input  logic                                 in_tlast,   // last_digit
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [dsdc_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [29:0] count
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dsdc_pkg::DIV_CFG_W-1:0]       cfg_data    // divisor
);

  localparam int unsigned IDX_W = $clog2(MAX_DIVISOR);
  localparam int unsigned DIV_W = $clog2(MAX_DIVISOR + 1);
  localparam int unsigned CMP_W = (DIV_W > dsdc_pkg::DIV_CFG_W) ? DIV_W : dsdc_pkg::DIV_CFG_W;
  localparam int unsigned DW    = dsdc_pkg::DIGIT_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FOLD  = 3'd2;
  localparam logic [2:0] S_WIN   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]                      state_r;
  logic [IDX_W-1:0]                clr_r;
  logic [dsdc_pkg::DIV_CFG_W-1:0]  divisor_r;
  logic [DIV_W-1:0]                dv_r;
  logic [DIV_W-1:0]                dv_live;
  logic [CMP_W-1:0]                div_ext;
  logic [DW-1:0]                   dig_r;
  logic [DW-1:0]                   dig_sat;
  logic                            last_r;
  logic [IDX_W-1:0]                prefix_r;
  dsdc_pkg::cnt_t                  new0_r;
  dsdc_pkg::cnt_t                  result;
  logic                            out_valid_r;
  dsdc_pkg::cnt_t                  out_data_r;

  logic                            in_acc;
  logic                            fold_busy;
  logic                            fold_issue;
  logic [IDX_W-1:0]                fold_addr;
  dsdc_pkg::wr_t                   b_wr;
  logic                            prep_busy;
  logic                            win_busy;
  logic                            win_start;
  logic [IDX_W-1:0]                pr_next;
  dsdc_pkg::wr_t                   win_res;
  logic [IDX_W-1:0]                res_idx;

  // count store: entries already below the bound's prefix, one per remainder
  dsdc_pkg::cnt_t                  count_mem [MAX_DIVISOR];
  dsdc_pkg::cnt_t                  a_rd_r;
  logic                            a_we;
  logic [IDX_W-1:0]                a_addr;
  dsdc_pkg::cnt_t                  a_data;

  assign in_acc    = in_tvalid & in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // live divisor, clamped to 1 .. MAX_DIVISOR
  assign div_ext = CMP_W'(divisor_r);
  always_comb begin
    if (divisor_r == '0) begin
      dv_live = DIV_W'(1);
    end else if (div_ext > CMP_W'(MAX_DIVISOR)) begin
      dv_live = DIV_W'(MAX_DIVISOR);
    end else begin
      dv_live = DIV_W'(div_ext);
    end
  end

  assign dig_sat   = (in_tdata[DW-1:0] > dsdc_pkg::TOP_DIGIT) ? dsdc_pkg::TOP_DIGIT
                                                             : in_tdata[DW-1:0];
  assign win_start = (state_r == S_FOLD) && !fold_busy && !prep_busy;
  assign res_idx   = IDX_W'(win_res.addr);

  // the all-zero number drops out unless the bound's own digit sum counts
  always_comb begin
    if (pr_next == '0) begin
      result = new0_r;
    end else if (new0_r == '0) begin
      result = dsdc_pkg::MODULUS - dsdc_pkg::CNT_W'(1);
    end else begin
      result = new0_r - dsdc_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      divisor_r   <= dsdc_pkg::DIV_CFG_W'(1);
      prefix_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        divisor_r <= cfg_data;
      end
      // in S_OUT the output register is reloaded below instead
      if (out_valid_r && out_tready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + IDX_W'(1);
          if (clr_r == IDX_W'(MAX_DIVISOR - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= S_FOLD;
          end
        end
        S_FOLD: begin
          if (win_start) begin
            state_r <= S_WIN;
          end
        end
        S_WIN: begin
          if (!win_busy) begin
            prefix_r <= last_r ? '0 : pr_next;
            state_r  <= last_r ? S_OUT : S_IDLE;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      dig_r  <= dig_sat;
      last_r <= in_tlast;
      dv_r   <= dv_live;
    end
    if (win_res.we && res_idx == '0) begin
      new0_r <= win_res.data;
    end
    if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
      out_data_r <= result;
    end
  end

  // write side: clearing pass, zeroing behind the fold, then the new counts, or zeros on a bound's last digit
  always_comb begin
    a_we   = 1'b0;
    a_addr = fold_addr;
    a_data = '0;
    case (state_r)
      S_CLEAR: begin
        a_we   = 1'b1;
        a_addr = clr_r;
      end
      S_FOLD: begin
        a_we   = fold_issue;
        a_addr = fold_addr;
      end
      S_WIN: begin
        a_we   = win_res.we;
        a_addr = res_idx;
        a_data = last_r ? '0 : win_res.data;
      end
      default: a_we = 1'b0;
    endcase
  end

  // read returns the old entry when the same address is zeroed this cycle
  always_ff @(posedge clk) begin
    if (a_we) begin
      count_mem[a_addr] <= a_data;
    end
    a_rd_r <= count_mem[fold_addr];
  end

  dsdc_fold #(
    .MAX_DIVISOR (MAX_DIVISOR)
  ) u_fold (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .dv       (dv_r),
    .rd_data  (a_rd_r),
    .busy     (fold_busy),
    .rd_issue (fold_issue),
    .rd_addr  (fold_addr),
    .b_wr     (b_wr)
  );

  dsdc_window #(
    .MAX_DIVISOR (MAX_DIVISOR)
  ) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .prep_start (in_acc),
    .prefix     (prefix_r),
    .dig        (dig_r),
    .start      (win_start),
    .dv         (dv_r),
    .b_wr       (b_wr),
    .prep_busy  (prep_busy),
    .busy       (win_busy),
    .pr_next    (pr_next),
    .res        (win_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = dsdc_pkg::OUT_TDATA_W'(out_data_r);

  // fold and prefix work both start with the accepted item
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> fold_busy && prep_busy)
    else $error("fold or prefix unit not started by accepted item");

  // the window never overlaps the fold pass
  a_win_after_fold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WIN |-> !fold_busy)
    else $error("window running while fold still busy");

  // new counts only land on live remainders
  a_res_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    win_res.we |-> (DIV_W'(res_idx) < dv_r))
    else $error("window result beyond live divisor");

  // every written count is reduced
  a_res_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    win_res.we |-> (win_res.data < dsdc_pkg::MODULUS))
    else $error("window result not reduced modulo");

endmodule

/* src/dsdc_fold.sv */
// folds the count store into one sum per live remainder
module dsdc_fold #(
  parameter int unsigned MAX_DIVISOR = dsdc_pkg::DEF_MAX_DIVISOR
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic [$clog2(MAX_DIVISOR+1)-1:0]       dv,
  input  dsdc_pkg::cnt_t                         rd_data,
  output logic                                   busy,
  output logic                                   rd_issue,
  output logic [$clog2(MAX_DIVISOR)-1:0]         rd_addr,
  output dsdc_pkg::wr_t                          b_wr
);

  localparam int unsigned IDX_W = $clog2(MAX_DIVISOR);
  localparam int unsigned DIV_W = $clog2(MAX_DIVISOR + 1);
  localparam int unsigned SUM_W = DIV_W + 1;

  logic             issue_r;
  logic             v1_r;
  logic [IDX_W-1:0] t_r;
  logic [IDX_W-1:0] r_r;
  logic             first1_r;
  logic             last1_r;
  logic [IDX_W-1:0] t1_r;
  dsdc_pkg::cnt_t   acc_r;
  dsdc_pkg::cnt_t   acc_nxt;
  logic             grp_last;
  logic             t_end;

  // entries t, t+dv, t+2dv ... share one remainder
  assign grp_last = (SUM_W'(r_r) + SUM_W'(dv)) >= SUM_W'(MAX_DIVISOR);
  assign t_end    = (DIV_W'(t_r) + DIV_W'(1)) == dv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r <= 1'b0;
      v1_r    <= 1'b0;
    end else begin
      if (start) begin
        issue_r <= 1'b1;
      end else if (issue_r && grp_last && t_end) begin
        issue_r <= 1'b0;
      end
      v1_r <= issue_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      t_r <= '0;
      r_r <= '0;
    end else if (issue_r) begin
      if (grp_last) begin
        t_r <= t_r + IDX_W'(1);
        r_r <= t_r + IDX_W'(1);
      end else begin
        r_r <= IDX_W'(SUM_W'(r_r) + SUM_W'(dv));
      end
    end
    first1_r <= (r_r == t_r);
    last1_r  <= grp_last;
    t1_r     <= t_r;
    if (v1_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc_nxt = first1_r ? rd_data : dsdc_pkg::mod_add(acc_r, rd_data);

  assign busy     = issue_r | v1_r;
  assign rd_issue = issue_r;
  assign rd_addr  = r_r;

  assign b_wr.we   = v1_r & last1_r;
  assign b_wr.addr = dsdc_pkg::ADDR_MAX_W'(t1_r);
  assign b_wr.data = acc_nxt;

endmodule

/* src/dsdc_window.sv */
// folded sums store, ten-wide sliding window and prefix digit choices
module dsdc_window #(
  parameter int unsigned MAX_DIVISOR = dsdc_pkg::DEF_MAX_DIVISOR
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                prep_start,
  input  logic [$clog2(MAX_DIVISOR)-1:0]      prefix,
  input  logic [dsdc_pkg::DIGIT_W-1:0]        dig,
  input  logic                                start,
  input  logic [$clog2(MAX_DIVISOR+1)-1:0]    dv,
  input  dsdc_pkg::wr_t                       b_wr,
  output logic                                prep_busy,
  output logic                                busy,
  output logic [$clog2(MAX_DIVISOR)-1:0]      pr_next,
  output dsdc_pkg::wr_t                       res
);

  localparam int unsigned IDX_W = $clog2(MAX_DIVISOR);
  localparam int unsigned DIV_W = $clog2(MAX_DIVISOR + 1);
  localparam int unsigned J_W   = $clog2(MAX_DIVISOR + dsdc_pkg::WIN_LEN + 1);
  localparam int unsigned NPOS  = dsdc_pkg::WIN_LEN;
  localparam int unsigned DW    = dsdc_pkg::DIGIT_W;

  function automatic logic [IDX_W-1:0] inc_wrap(input logic [IDX_W-1:0] x,
                                                input logic [DIV_W-1:0] m);
    logic [DIV_W-1:0] s;
    s = DIV_W'(x) + DIV_W'(1);
    return (s == m) ? '0 : IDX_W'(s);
  endfunction

  dsdc_pkg::cnt_t   fold_mem [MAX_DIVISOR];
  dsdc_pkg::cnt_t   rd1_r;
  dsdc_pkg::cnt_t   rd2_r;

  logic             prep_r;
  logic             red_r;
  logic [IDX_W-1:0] run_r;
  logic [DW-1:0]    g_r;
  logic [IDX_W-1:0] pos_r [NPOS];

  logic             act_r;
  logic             v1_r;
  logic             v2_r;
  logic             v3_r;
  logic             res_we_r;
  logic [J_W-1:0]   j_r;
  logic [IDX_W-1:0] jm_r;
  logic [IDX_W-1:0] km_r;
  logic             sub1_r;
  logic             out1_r;
  logic             out2_r;
  logic             out3_r;
  logic [IDX_W-1:0] s1_r;
  logic [IDX_W-1:0] s2_r;
  logic [IDX_W-1:0] s3_r;
  logic [IDX_W-1:0] res_addr_r;
  dsdc_pkg::cnt_t   diff_r;
  dsdc_pkg::cnt_t   w_r;
  dsdc_pkg::cnt_t   res_data_r;

  logic             sub_now;
  logic             out_now;
  logic [J_W-1:0]   j_last;
  logic [DW-1:0]    hits;
  logic             run_big;

  // folded sums, two read ports for window head and tail
  always_ff @(posedge clk) begin
    if (b_wr.we) begin
      fold_mem[IDX_W'(b_wr.addr)] <= b_wr.data;
    end
    rd1_r <= fold_mem[jm_r];
    rd2_r <= fold_mem[km_r];
  end

  // prefix positions (prefix + g) mod dv, after reducing the prefix
  assign run_big = DIV_W'(run_r) >= dv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_r <= 1'b0;
    end else if (prep_start) begin
      prep_r <= 1'b1;
    end else if (prep_r && !red_r && g_r == dsdc_pkg::TOP_DIGIT) begin
      prep_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (prep_start) begin
      run_r <= prefix;
      red_r <= 1'b1;
      g_r   <= '0;
    end else if (prep_r) begin
      if (red_r) begin
        if (run_big) begin
          run_r <= IDX_W'(DIV_W'(run_r) - dv);
        end else begin
          red_r <= 1'b0;
        end
      end else begin
        pos_r[g_r] <= run_r;
        run_r      <= inc_wrap(run_r, dv);
        g_r        <= g_r + DW'(1);
      end
    end
  end

  assign pr_next = pos_r[dig];

  // window over j = 0 .. dv+8, one result per j from 9 on
  assign j_last  = J_W'(dv) + J_W'(NPOS - 2);
  assign sub_now = j_r >= J_W'(NPOS);
  assign out_now = j_r >= J_W'(NPOS - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r    <= 1'b0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      res_we_r <= 1'b0;
    end else begin
      if (start) begin
        act_r <= 1'b1;
      end else if (act_r && j_r == j_last) begin
        act_r <= 1'b0;
      end
      v1_r     <= act_r;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      res_we_r <= v3_r & out3_r;
    end
  end

  always_comb begin
    hits = '0;
    for (int g = 0; g < NPOS - 1; g++) begin
      if (DW'(g) < dig && pos_r[g] == s3_r) begin
        hits = hits + DW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      j_r  <= '0;
      jm_r <= '0;
      km_r <= '0;
      w_r  <= '0;
    end else begin
      if (act_r) begin
        j_r  <= j_r + J_W'(1);
        jm_r <= inc_wrap(jm_r, dv);
        if (sub_now) begin
          km_r <= inc_wrap(km_r, dv);
        end
      end
      if (v2_r) begin
        w_r <= dsdc_pkg::mod_add(w_r, diff_r);
      end
    end
    sub1_r <= sub_now;
    out1_r <= out_now;
    s1_r   <= jm_r;
    if (v1_r) begin
      diff_r <= dsdc_pkg::mod_sub(rd1_r, sub1_r ? rd2_r : '0);
    end
    out2_r     <= out1_r;
    s2_r       <= s1_r;
    out3_r     <= out2_r;
    s3_r       <= s2_r;
    res_addr_r <= s3_r;
    res_data_r <= dsdc_pkg::mod_add(w_r, dsdc_pkg::CNT_W'(hits));
  end

  assign prep_busy = prep_r;
  assign busy      = act_r | v1_r | v2_r | v3_r | res_we_r;
  assign res.we    = res_we_r;
  assign res.addr  = dsdc_pkg::ADDR_MAX_W'(res_addr_r);
  assign res.data  = res_data_r;

endmodule

/* dv/digit_sum_divisible_counter_tb.sv */
// self-checking testbench for the digit sum divisible counter
module digit_sum_divisible_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_DIV      = dsdc_pkg::DEF_MAX_DIVISOR;
  // one digit can cost two store passes plus a fold of a stale prefix
  localparam int unsigned DIGIT_CYCLES = 5 * MAX_DIV;
  // long receiver hold-off, long enough for two results to pile up
  localparam int unsigned HOLD_CYCLES  = 8000;
  localparam int unsigned HOLD_PHASE   = 4;
  // a span this long with no handshake on any channel means the block has hung
  localparam int unsigned STALL_LIMIT  = 40000;
  localparam int unsigned TOP_DIG      = 9;

  typedef enum {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SINK_STALL, FLOW_BOTH} flow_mode_t;

  // predictor and store of expected counts
  class count_scoreboard;
    logic [dsdc_pkg::DIV_CFG_W-1:0] divisor_reg;
    dsdc_pkg::cnt_t                 below_tally[MAX_DIV];
    int unsigned                    prefix_rem;
    dsdc_pkg::cnt_t                 expected_counts[$];
    int unsigned                    mismatches;
    int unsigned                    counts_checked;
    int unsigned                    digits_noted;

    function new();
      divisor_reg    = 8'd1;
      mismatches     = 0;
      counts_checked = 0;
      digits_noted   = 0;
      clear_bound();
    endfunction

    function void clear_bound();
      foreach (below_tally[r]) below_tally[r] = '0;
      prefix_rem = 0;
    endfunction

    function int unsigned live_divisor();
      if (divisor_reg == 0) return 1;
      if (divisor_reg > MAX_DIV) return MAX_DIV;
      return divisor_reg;
    endfunction

    // one accepted digit: advance the remainder tallies, maybe predict a count
    function void note_digit(logic [dsdc_pkg::DIGIT_W-1:0] digit, logic last);
      longint unsigned acc[MAX_DIV];
      longint unsigned total;
      int unsigned     dv;
      int unsigned     dig;
      dv  = live_divisor();
      dig = (digit > TOP_DIG) ? TOP_DIG : digit;
      digits_noted++;
      foreach (acc[r]) acc[r] = 0;
      // strings already below the bound take any next digit
      for (int unsigned r = 0; r < MAX_DIV; r++) begin
        if (below_tally[r] != 0) begin
          for (int unsigned g = 0; g <= TOP_DIG; g++) begin
            acc[(r + g) % dv] += below_tally[r];
          end
        end
      end
      // the bound's own prefix drops below it with any smaller digit
      for (int unsigned g = 0; g < dig; g++) begin
        acc[(prefix_rem + g) % dv] += 1;
      end
      for (int unsigned r = 0; r < MAX_DIV; r++) begin
        below_tally[r] = dsdc_pkg::cnt_t'(acc[r] % longint'(dsdc_pkg::MODULUS));
      end
      prefix_rem = (prefix_rem + dig) % dv;
      if (last) begin
        total = below_tally[0];
        if (prefix_rem == 0) total += 1;
        // drop the all-zero number
        total = (total + longint'(dsdc_pkg::MODULUS) - 1) % longint'(dsdc_pkg::MODULUS);
        expected_counts.push_back(dsdc_pkg::cnt_t'(total));
        clear_bound();
      end
    endfunction

    function void check_count(logic [dsdc_pkg::OUT_TDATA_W-1:0] tdata);
      dsdc_pkg::cnt_t want;
      if (expected_counts.size() == 0) begin
        $error("count: no result expected, actual %0d", tdata[dsdc_pkg::CNT_W-1:0]);
        mismatches++;
        return;
      end
      want = expected_counts.pop_front();
      counts_checked++;
      if (tdata[dsdc_pkg::CNT_W-1:0] !== want) begin
        $error("count: expected %0d, actual %0d", want, tdata[dsdc_pkg::CNT_W-1:0]);
        mismatches++;
      end
      if (tdata[dsdc_pkg::OUT_TDATA_W-1:dsdc_pkg::CNT_W] !== '0) begin
        $error("tdata padding: expected 0, actual %0h",
               tdata[dsdc_pkg::OUT_TDATA_W-1:dsdc_pkg::CNT_W]);
        mismatches++;
      end
    endfunction
  endclass

  // every input of the block known from time zero
  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [dsdc_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;  // [3:0] digit
  logic                             in_tlast   = 1'b0; // last_digit
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [dsdc_pkg::OUT_TDATA_W-1:0] out_tdata;        // [29:0] count
  logic                             cfg_valid  = 1'b0;
  logic                             cfg_ready;
  logic [dsdc_pkg::DIV_CFG_W-1:0]   cfg_data   = '0;  // divisor

  count_scoreboard sb;

  // traffic shaping, set per phase by the stimulus process
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned phase_no       = 0;
  int unsigned settings_used  = 0;

  // receiver-side hold-off state, owned by the receiver process, and the watchdog's idle count
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned idle_cycles = 0;

  digit_sum_divisible_counter #(
    .MAX_DIVISOR(MAX_DIV)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // receiver: random back-pressure, plus one long hold-off during the fourth random phase
  always @(posedge clk) begin
    if (hold_left == 0 && !hold_done && phase_no == HOLD_PHASE) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // result monitor: outputs are sampled before this edge's updates land
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_count(out_tdata);
    end
  end

  // watchdog: counts cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // offer one digit item, with random idle cycles ahead of it, and wait for acceptance
  task automatic send_digit(input logic [dsdc_pkg::DIGIT_W-1:0] digit, input logic last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= dsdc_pkg::IN_TDATA_W'(digit);
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_digit(digit, last);
  endtask

  // a bound of random digits, mostly decimal, now and then above nine
  task automatic send_bound(input int unsigned len, input bit close);
    logic [dsdc_pkg::DIGIT_W-1:0] digit;
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 8) digit = dsdc_pkg::DIGIT_W'($urandom_range(10, 15));
      else                           digit = dsdc_pkg::DIGIT_W'($urandom_range(0, 9));
      send_digit(digit, close && (i == len - 1));
    end
  endtask

  task automatic write_divisor(input logic [dsdc_pkg::DIV_CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.divisor_reg = value;
    settings_used++;
  endtask

  // drain all expected counts, then let a possibly open digit finish
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_counts.size() != 0) @(posedge clk);
    repeat (DIGIT_CYCLES) @(posedge clk);
  endtask

  task automatic set_flow(input flow_mode_t mode);
    case (mode)
      FLOW_FREE: begin
        src_idle_pct = 0;  sink_stall_pct = 0;
      end
      FLOW_SRC_IDLE: begin
        src_idle_pct = 73; sink_stall_pct = 0;
      end
      FLOW_SINK_STALL: begin
        src_idle_pct = 0;  sink_stall_pct = 73;
      end
      default: begin
        src_idle_pct = 17; sink_stall_pct = 17;
      end
    endcase
  endtask

  // one random phase: a divisor setting, a traffic shape and a digit budget
  task automatic run_phase(input logic [dsdc_pkg::DIV_CFG_W-1:0] div,
                           input flow_mode_t mode,
                           input int unsigned budget, input bit leave_open);
    int unsigned sent;
    int unsigned len;
    settle();
    write_divisor(div);
    set_flow(mode);
    phase_no++;
    sent = 0;
    while (sent < budget) begin
      // mostly short bounds, a few long ones that wrap the modulus
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      send_bound(len, 1'b1);
      sent += len;
    end
    // an unfinished bound carries over a divisor change into the next phase
    if (leave_open) send_bound(3, 1'b0);
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset divisor of one, bound zero, a digit above nine, all nines
    set_flow(FLOW_FREE);
    send_digit(4'd0, 1'b1);
    send_digit(4'd15, 1'b1);
    send_digit(4'd9, 1'b0);
    send_digit(4'd9, 1'b0);
    send_digit(4'd9, 1'b1);
    // leading zeros under a divisor of ten
    settle();
    write_divisor(8'd10);
    send_digit(4'd0, 1'b0);
    send_digit(4'd0, 1'b0);
    send_digit(4'd1, 1'b0);
    send_digit(4'd9, 1'b1);
    for (int i = 0; i < 5; i++) send_digit(4'd9, i == 4);
    // largest divisor, largest digit code throughout
    settle();
    write_divisor(8'(MAX_DIV));
    for (int i = 0; i < 6; i++) send_digit(4'd15, i == 5);

    // random phases: extremes, zero and oversized divisors, all traffic shapes
    run_phase(8'd128, FLOW_FREE,       135, 1'b0);
    run_phase(8'd1,   FLOW_SRC_IDLE,   135, 1'b0);
    run_phase(8'd7,   FLOW_SINK_STALL, 135, 1'b0);
    run_phase(8'd0,   FLOW_BOTH,       135, 1'b0);
    run_phase(8'd255, FLOW_FREE,       135, 1'b0);
    run_phase(8'd2,   FLOW_SRC_IDLE,   135, 1'b0);
    run_phase(8'd100, FLOW_SINK_STALL, 135, 1'b1);
    run_phase(8'd3,   FLOW_BOTH,       135, 1'b0);
    run_phase(8'd129, FLOW_FREE,       135, 1'b0);
    run_phase(8'($urandom_range(1, MAX_DIV)), FLOW_SRC_IDLE, 135, 1'b0);

    settle();
    $display("covered %0d digit items and %0d checked counts over %0d divisor settings,",
             sb.digits_noted, sb.counts_checked, settings_used);
    $display("with free, idling, stalling and mixed flow plus one long receiver hold-off");
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* digit_sum_divisible_counter.f */
src/dsdc_pkg.sv
src/dsdc_fold.sv
src/dsdc_window.sv
src/digit_sum_divisible_counter.sv
dv/digit_sum_divisible_counter_tb.sv
